// ===== rtl/tbes_pkg.sv =====
// Shared constants and types for the tone burst envelope shaper.
package tbes_pkg;

	localparam int RAMP_WIDTH = 12;

	typedef logic [RAMP_WIDTH-1:0] ramp_t;

	// Configuration register indexes
	localparam logic REG_ATTACK  = 1'b0;
	localparam logic REG_RELEASE = 1'b1;

endpackage

// ===== rtl/tone_burst_envelope_shaper_unit.sv =====
// Tone burst envelope shaper: linear attack and release ramps on a sample stream.
//
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+----------------------------------------
// input    | in  | in_valid / in_stall  | sample_in, first_of_burst, burst_length
// output   | out | out_valid / out_stall| sample_out
// config   | in  | cfg_write            | cfg_index, cfg_data
//
// Each sample is loaded as it enters, then for each active ramp it passes a
// bit-serial shift-add multiply and a restoring divide, and at last the
// result is handed over. Both ramps share one multiply/divide datapath, so
// where both ramps overlap the release ramp is worked after the attack ramp.
// Reset clears the ramp registers, the burst position and the output valid.
// A stalled output holds its transfer; the engine takes the next sample as soon
// as its own result has moved into the output register.
module tone_burst_envelope_shaper_unit #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int LENGTH_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [tbes_pkg::RAMP_WIDTH-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           first_of_burst,
	input  logic [LENGTH_WIDTH-1:0]        burst_length,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int LW   = LENGTH_WIDTH;
	localparam int RW   = tbes_pkg::RAMP_WIDTH;
	// width wide enough to compare positions against ramp lengths
	localparam int CW   = (LW > RW) ? LW : RW;
	// product / dividend register width
	localparam int PW   = SW + LW;
	localparam int CNTW = $clog2(PW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic PH_ATTACK  = 1'b0;
	localparam logic PH_RELEASE = 1'b1;

	// configuration
	tbes_pkg::ramp_t attack_q;
	tbes_pkg::ramp_t release_q;

	// control
	logic [1:0]      state_q;
	logic [LW-1:0]   pos_q;
	logic [CNTW-1:0] cnt_q;
	logic            phase_q;
	logic            do_rel_q;
	logic            out_valid_q;

	// datapath
	logic [SW-1:0]   mag_q;
	logic            neg_q;
	logic [PW-1:0]   prod_q;
	tbes_pkg::ramp_t rem_q;
	tbes_pkg::ramp_t div_q;
	tbes_pkg::ramp_t rel_len_q;
	logic [LW-1:0]   rel_mult_q;
	logic [SW-1:0]   out_q;

	// ---------------------------------------------------------------------
	// Decode of the incoming sample
	// ---------------------------------------------------------------------
	logic            in_xfer;
	logic [LW-1:0]   pos_cur;
	tbes_pkg::ramp_t att_len;
	tbes_pkg::ramp_t rel_len;
	logic            in_attack;
	logic            in_release;
	logic [LW-1:0]   rel_floor;
	logic [LW-1:0]   rel_mult;
	logic [SW-1:0]   in_mag;
	logic            len_below_att;
	logic            len_below_rel;

	assign in_xfer  = in_valid && !in_stall;
	assign pos_cur  = first_of_burst ? '0 : pos_q;

	// clamp both ramps to the burst length; a clamped value fits the ramp width
	assign len_below_att = CW'(burst_length) < CW'(attack_q);
	assign len_below_rel = CW'(burst_length) < CW'(release_q);
	assign att_len = len_below_att ? RW'(burst_length) : attack_q;
	assign rel_len = len_below_rel ? RW'(burst_length) : release_q;

	assign in_attack  = CW'(pos_cur) < CW'(att_len);
	assign rel_floor  = burst_length - LW'(rel_len);
	assign in_release = (rel_len != '0) && (pos_cur < burst_length)
		&& (pos_cur >= rel_floor);
	assign rel_mult   = burst_length - LW'(1) - pos_cur;

	// work on the magnitude; truncation toward zero then keeps the sign apart
	assign in_mag = sample_in[SW-1] ? (SW'(0) - $unsigned(sample_in)) : $unsigned(sample_in);

	// ---------------------------------------------------------------------
	// Serial arithmetic steps
	// ---------------------------------------------------------------------
	logic [SW:0]   mul_sum;
	logic [RW:0]   div_trial;
	logic [RW:0]   div_diff;
	logic          div_ge;
	logic [SW-1:0] result;

	// shift-add: add the multiplicand into the upper half when the low bit is set
	assign mul_sum   = {1'b0, prod_q[PW-1:LW]} + (prod_q[0] ? {1'b0, mag_q} : '0);
	// restoring divide: bring in one dividend bit, subtract when it fits
	assign div_trial = {rem_q, prod_q[PW-1]};
	assign div_diff  = div_trial - {1'b0, div_q};
	assign div_ge    = div_trial >= {1'b0, div_q};

	assign result = neg_q ? (SW'(0) - mag_q) : mag_q;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			release_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				tbes_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				tbes_pkg::REG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Sequencer: accept, multiply, divide, repeat for the release ramp where both apply, hand off
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cnt_q       <= '0;
			phase_q     <= PH_ATTACK;
			do_rel_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the output when a finished result moves in, drop it once taken
			if (state_q == ST_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						// advance the burst position, saturating at all ones
						pos_q    <= (pos_cur != '1) ? pos_cur + LW'(1) : pos_cur;
						do_rel_q <= in_release;
						cnt_q    <= CNTW'(LW - 1);
						if (in_attack) begin
							phase_q <= PH_ATTACK;
							state_q <= ST_MUL;
						end else if (in_release) begin
							phase_q <= PH_RELEASE;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						cnt_q   <= CNTW'(PW - 1);
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (phase_q == PH_ATTACK && do_rel_q) begin
							phase_q <= PH_RELEASE;
							cnt_q   <= CNTW'(LW - 1);
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						cnt_q <= cnt_q - CNTW'(1);
					end
				end
				ST_DONE: begin
					// hold until the output register is free or being emptied
					if (!out_valid_q || !out_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					mag_q      <= in_mag;
					neg_q      <= sample_in[SW-1];
					rem_q      <= '0;
					rel_len_q  <= rel_len;
					rel_mult_q <= rel_mult;
					if (in_attack) begin
						prod_q <= {SW'(0), pos_cur};
						div_q  <= att_len;
					end else begin
						prod_q <= {SW'(0), rel_mult};
						div_q  <= rel_len;
					end
				end
			end
			ST_MUL: begin
				prod_q <= {mul_sum, prod_q[LW-1:1]};
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					// quotient is complete in the low bits after the last shift
					mag_q <= {prod_q[SW-2:0], div_ge};
				end
				if (cnt_q == '0 && phase_q == PH_ATTACK && do_rel_q) begin
					// load the release ramp operands
					prod_q <= {SW'(0), rel_mult_q};
					div_q  <= rel_len_q;
					rem_q  <= '0;
				end else begin
					rem_q  <= div_ge ? div_diff[RW-1:0] : div_trial[RW-1:0];
					prod_q <= {prod_q[PW-2:0], div_ge};
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall)
					out_q <= result;
			end
			default: ;
		endcase
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = $signed(out_q);

endmodule
